// ----- design/phr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and sizes for the priority ordered handler table.
// No dependencies; every other file imports this package.
package phr_pkg;

	localparam int MAX_ENTRIES = 32;
	localparam int FILL_W      = $clog2(MAX_ENTRIES + 1);

	typedef logic        [15:0] id_t;
	typedef logic signed [15:0] prio_t;
	typedef logic        [2:0]  status_t;
	typedef logic        [FILL_W-1:0] fill_t;

	// Request actions
	localparam logic ACT_REGISTER = 1'b0;
	localparam logic ACT_LIST     = 1'b1;

	// Result status codes
	localparam status_t ST_INSERTED  = 3'd0;
	localparam status_t ST_DUPLICATE = 3'd1;
	localparam status_t ST_FULL      = 3'd2;
	localparam status_t ST_ENTRY     = 3'd3;
	localparam status_t ST_EMPTY     = 3'd4;

	// Commands broadcast to every cell of the chain
	typedef struct packed {
		logic rotate;
		logic insert;
	} cell_ctl_t;

endpackage

// ----- design/phr_ifs.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and result words.
// Depends on phr_pkg for the payload types.
interface phr_req_if import phr_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  action;
	id_t   handler_id;
	prio_t prio;

	modport source (output valid, action, handler_id, prio, input ready);
	modport sink   (input valid, action, handler_id, prio, output ready);
endinterface

interface phr_rsp_if import phr_pkg::*; ();
	logic    valid;
	logic    ready;
	status_t status;
	id_t     entry_id;
	prio_t   entry_prio;
	logic    last;

	modport source (output valid, status, entry_id, entry_prio, last, input ready);
	modport sink   (input valid, status, entry_id, entry_prio, last, output ready);
endinterface

// ----- design/phr_cell.sv -----
`timescale 1ns / 1ps
// One slot of the sorted chain: holds an (id, priority) pair and trades it
// with its neighbors on insert and rotate. Depends on phr_pkg.
module phr_cell import phr_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  id_t       new_id,
	input  prio_t     new_prio,
	input  logic      occupied,
	input  logic      tail,
	input  logic      prev_go,
	input  id_t       prev_id,
	input  prio_t     prev_prio,
	input  id_t       next_id,
	input  prio_t     next_prio,
	input  id_t       head_id,
	input  prio_t     head_prio,
	output logic      go,
	output id_t       id,
	output prio_t     prio
);

	id_t   id_q;
	prio_t prio_q;

	// The new pair belongs at or above this slot when the slot is empty or not higher
	assign go   = !occupied || (new_prio >= prio_q);
	assign id   = id_q;
	assign prio = prio_q;

	// Take the new pair at the boundary, shift down below it, rotate toward the head
	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (go && !prev_go) begin
				id_q   <= new_id;
				prio_q <= new_prio;
			end else if (prev_go) begin
				id_q   <= prev_id;
				prio_q <= prev_prio;
			end
		end else if (ctl.rotate) begin
			if (tail) begin
				id_q   <= head_id;
				prio_q <= head_prio;
			end else begin
				id_q   <= next_id;
				prio_q <= next_prio;
			end
		end
	end

endmodule

// ----- design/priority_ordered_handler_table.sv -----
`timescale 1ns / 1ps
// Channel | Dir | Word
// req     | in  | action, handler_id, prio
// rsp     | out | status, entry_id, entry_prio, last
//
// A register word with N entries held rotates the chain N times in S_SCAN to
// check the id, inserts if new in S_DECIDE and answers in S_RESULT; a full
// table skips to S_RESULT. A list word gives one result per rotation, or one
// empty result if empty; rsp stalls freeze the list rotation. req is taken
// only when idle. Reset clears the fill count and control; cell contents are
// not reset. Depends on phr_pkg, phr_ifs and phr_cell.
module priority_ordered_handler_table import phr_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	phr_req_if.sink        req,
	phr_rsp_if.source      rsp
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_RESULT = 3'd3;
	localparam logic [2:0] S_LIST   = 3'd4;

	logic [2:0] state_q;
	fill_t      fill_q;
	fill_t      cnt_q;
	logic       dup_q;
	status_t    res_status_q;
	id_t        new_id_q;
	prio_t      new_prio_q;

	logic       rsp_valid_q;
	status_t    rsp_status_q;
	id_t        rsp_id_q;
	prio_t      rsp_prio_q;
	logic       rsp_last_q;

	cell_ctl_t  cell_ctl;
	logic       out_free;
	logic       load_out;
	logic       cnt_end;
	logic       accept;

	id_t        cell_id   [MAX_ENTRIES];
	prio_t      cell_prio [MAX_ENTRIES];
	logic       cell_go   [MAX_ENTRIES];

	assign accept   = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign cnt_end  = (FILL_W'(cnt_q + 1'b1) == fill_q);
	assign load_out = ((state_q == S_RESULT) || (state_q == S_LIST)) && out_free;

	assign cell_ctl.rotate = (state_q == S_SCAN) || ((state_q == S_LIST) && out_free);
	assign cell_ctl.insert = (state_q == S_DECIDE) && !dup_q;

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_status_q;
	assign rsp.entry_id   = rsp_id_q;
	assign rsp.entry_prio = rsp_prio_q;
	assign rsp.last       = rsp_last_q;

	// Chain of cells, head at index zero
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		logic  prev_go;
		id_t   prev_id;
		prio_t prev_prio;
		id_t   next_id;
		prio_t next_prio;

		if (i == 0) begin : g_first
			assign prev_go   = 1'b0;
			assign prev_id   = new_id_q;
			assign prev_prio = new_prio_q;
		end else begin : g_mid
			assign prev_go   = cell_go[i-1];
			assign prev_id   = cell_id[i-1];
			assign prev_prio = cell_prio[i-1];
		end

		if (i == MAX_ENTRIES - 1) begin : g_last
			assign next_id   = cell_id[0];
			assign next_prio = cell_prio[0];
		end else begin : g_inner
			assign next_id   = cell_id[i+1];
			assign next_prio = cell_prio[i+1];
		end

		phr_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl),
			.new_id    (new_id_q),
			.new_prio  (new_prio_q),
			.occupied  (FILL_W'(i) < fill_q),
			.tail      (FILL_W'(i + 1) == fill_q),
			.prev_go   (prev_go),
			.prev_id   (prev_id),
			.prev_prio (prev_prio),
			.next_id   (next_id),
			.next_prio (next_prio),
			.head_id   (cell_id[0]),
			.head_prio (cell_prio[0]),
			.go        (cell_go[i]),
			.id        (cell_id[i]),
			.prio      (cell_prio[i])
		);
	end

	// Sequence one request word at a time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fill_q       <= '0;
			cnt_q        <= '0;
			dup_q        <= 1'b0;
			res_status_q <= ST_INSERTED;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= '0;
						dup_q <= 1'b0;
						if (req.action == ACT_LIST) begin
							if (fill_q == '0) begin
								res_status_q <= ST_EMPTY;
								state_q      <= S_RESULT;
							end else begin
								state_q <= S_LIST;
							end
						end else if (fill_q == FILL_W'(MAX_ENTRIES)) begin
							res_status_q <= ST_FULL;
							state_q      <= S_RESULT;
						end else if (fill_q == '0) begin
							state_q <= S_DECIDE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					dup_q <= dup_q || (cell_id[0] == new_id_q);
					cnt_q <= FILL_W'(cnt_q + 1'b1);
					if (cnt_end) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (dup_q) begin
						res_status_q <= ST_DUPLICATE;
					end else begin
						res_status_q <= ST_INSERTED;
						fill_q       <= FILL_W'(fill_q + 1'b1);
					end
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_LIST: begin
					if (out_free) begin
						cnt_q <= FILL_W'(cnt_q + 1'b1);
						if (cnt_end) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture the request payload and load result words
	always_ff @(posedge clk) begin
		if (accept) begin
			new_id_q   <= req.handler_id;
			new_prio_q <= req.prio;
		end
		if (load_out) begin
			if (state_q == S_LIST) begin
				rsp_status_q <= ST_ENTRY;
				rsp_id_q     <= cell_id[0];
				rsp_prio_q   <= cell_prio[0];
				rsp_last_q   <= cnt_end;
			end else begin
				rsp_status_q <= res_status_q;
				rsp_id_q     <= '0;
				rsp_prio_q   <= '0;
				rsp_last_q   <= 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(MAX_ENTRIES))
		else $error("fill count beyond table size");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != $past(fill_q) |-> fill_q == FILL_W'($past(fill_q) + 1'b1))
		else $error("fill count moved by other than one");

	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while previous word in work");

	a_list_rows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LIST) |-> (cnt_q < fill_q))
		else $error("list walked past the held entries");
`endif

endmodule
